// ===== hdl/dsm_pkg.sv =====
// Shared types and constants of the dive safety stop monitor.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none

package dsm_pkg;

	// Field widths
	localparam int DEPTH_W   = 10;
	localparam int NSM_W     = 10;
	localparam int TICK_W    = 8;
	localparam int SEC_W     = 6;
	localparam int HOUR_W    = 8;
	localparam int STOPSEC_W = 10;

	// Configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Register map, in word order
	typedef enum logic [2:0] {
		REG_TICKS_PER_SECOND    = 3'd0,
		REG_SAFETY_STOP_SECONDS = 3'd1,
		REG_REQUIRE_STOP_DEPTH  = 3'd2,
		REG_STOP_DEEP_LIMIT     = 3'd3,
		REG_STOP_SHALLOW_LIMIT  = 3'd4,
		REG_DIVE_START_DEPTH    = 3'd5,
		REG_ASCENT_LIMIT        = 3'd6,
		REG_START_IN_DIVE       = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [TICK_W-1:0]    RST_TICKS_PER_SECOND    = 8'd1;
	localparam logic [STOPSEC_W-1:0] RST_SAFETY_STOP_SECONDS = 10'd180;
	localparam logic [DEPTH_W-1:0]   RST_REQUIRE_STOP_DEPTH  = 10'd30;
	localparam logic [DEPTH_W-1:0]   RST_STOP_DEEP_LIMIT     = 10'd20;
	localparam logic [DEPTH_W-1:0]   RST_STOP_SHALLOW_LIMIT  = 10'd15;
	localparam logic [DEPTH_W-1:0]   RST_DIVE_START_DEPTH    = 10'd4;
	localparam logic [DEPTH_W-1:0]   RST_ASCENT_LIMIT        = 10'd1;
	localparam logic                 RST_START_IN_DIVE       = 1'b1;

	// Clock rollover points
	localparam logic [SEC_W-1:0]  SEC_PER_MIN = 6'd59;
	localparam logic [SEC_W-1:0]  MIN_PER_HR  = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_MAX    = 8'd255;

endpackage : dsm_pkg

`default_nettype wire

// ===== hdl/dsm_in_if.sv =====
// Sample channel: valid/ready handshake carrying one depth sample item.
// Depends on dsm_pkg for field widths.
`default_nettype none

interface dsm_in_if;
	logic                               valid;
	logic                               ready;
	logic        [dsm_pkg::DEPTH_W-1:0] depth_sample;
	logic signed [dsm_pkg::NSM_W-1:0]   no_stop_minutes;

	modport source (output valid, depth_sample, no_stop_minutes, input ready);
	modport sink   (input valid, depth_sample, no_stop_minutes, output ready);
endinterface : dsm_in_if

`default_nettype wire

// ===== hdl/dsm_out_if.sv =====
// Result channel: valid/ready handshake carrying one monitor status item.
// Depends on dsm_pkg for field widths.
`default_nettype none

interface dsm_out_if;
	logic                                valid;
	logic                                ready;
	logic                                diving;
	logic [dsm_pkg::DEPTH_W-1:0]         max_depth;
	logic [dsm_pkg::HOUR_W-1:0]          dive_hours;
	logic [dsm_pkg::SEC_W-1:0]           dive_minutes;
	logic [dsm_pkg::SEC_W-1:0]           dive_seconds;
	logic                                stop_required;
	logic                                stop_active;
	logic [dsm_pkg::STOPSEC_W-1:0]       stop_seconds_left;
	logic                                ascent_alarm;
	logic                                no_stop_alarm;
	logic                                buzzer_on;
	logic                                led_on;

	modport source (
		output valid, diving, max_depth, dive_hours, dive_minutes, dive_seconds,
		       stop_required, stop_active, stop_seconds_left, ascent_alarm,
		       no_stop_alarm, buzzer_on, led_on,
		input  ready
	);
	modport sink (
		input  valid, diving, max_depth, dive_hours, dive_minutes, dive_seconds,
		       stop_required, stop_active, stop_seconds_left, ascent_alarm,
		       no_stop_alarm, buzzer_on, led_on,
		output ready
	);
endinterface : dsm_out_if

`default_nettype wire

// ===== hdl/dive_safety_stop_monitor.sv =====
// Dive safety stop monitor top level: sample register, update logic, result register.
// Depends on dsm_pkg, dsm_in_if and dsm_out_if.
//
// Each sample item is one timer tick. While diving the tick first advances the
// dive clock (sub-second ticks, seconds, minutes, hours saturating at 255) and,
// on each whole second, counts the safety stop down while the previous depth
// lies inside the stop band; the new depth then updates maximum depth, the
// owed/active stop state and the ascent-rate and no-stop alarms. The block
// takes one item per clock while the result register is empty or taken: an item is
// loaded into the sample register at the accepting edge, the update runs in the
// single logic stage behind it, and the result is loaded into the result register
// as it frees. Both registers hold under back-pressure; the sample channel is refused
// only while both registers are full and the result is not being taken, so with a
// ready receiver items flow back to back. Settings are to be written through the
// APB port while no item is in flight; the block does not enforce this. The dive
// flag takes the reset value of start_in_dive and stays set until reset.
`default_nettype none

module dive_safety_stop_monitor (
	input  wire                                  clk,
	input  wire                                  arst_n,
	dsm_in_if.sink                               samples,
	dsm_out_if.source                            results,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [dsm_pkg::APB_AW-1:0]           paddr,
	input  wire  [dsm_pkg::APB_DW-1:0]           pwdata,
	output logic [dsm_pkg::APB_DW-1:0]           prdata,
	output logic                                 pready
);

	// Configuration registers
	logic [dsm_pkg::TICK_W-1:0]    tps_q;
	logic [dsm_pkg::STOPSEC_W-1:0] stop_len_q;
	logic [dsm_pkg::DEPTH_W-1:0]   req_depth_q;
	logic [dsm_pkg::DEPTH_W-1:0]   deep_lim_q;
	logic [dsm_pkg::DEPTH_W-1:0]   shallow_lim_q;
	logic [dsm_pkg::DEPTH_W-1:0]   start_depth_q;
	logic [dsm_pkg::DEPTH_W-1:0]   ascent_lim_q;
	logic                          start_in_dive_q;

	// Monitor state
	logic                          dive_q;
	logic [dsm_pkg::DEPTH_W-1:0]   last_depth_q;
	logic [dsm_pkg::DEPTH_W-1:0]   deepest_q;
	logic [dsm_pkg::TICK_W-1:0]    tick_q;
	logic [dsm_pkg::SEC_W-1:0]     sec_q;
	logic [dsm_pkg::SEC_W-1:0]     min_q;
	logic [dsm_pkg::HOUR_W-1:0]    hour_q;
	logic                          owe_q;
	logic                          in_stop_q;
	logic [dsm_pkg::STOPSEC_W-1:0] stop_left_q;
	logic                          ascent_q;
	logic                          nostop_q;

	// Next state
	logic                          dive_d;
	logic [dsm_pkg::DEPTH_W-1:0]   deepest_d;
	logic [dsm_pkg::TICK_W-1:0]    tick_d;
	logic [dsm_pkg::SEC_W-1:0]     sec_d;
	logic [dsm_pkg::SEC_W-1:0]     min_d;
	logic [dsm_pkg::HOUR_W-1:0]    hour_d;
	logic                          owe_d;
	logic                          in_stop_d;
	logic [dsm_pkg::STOPSEC_W-1:0] stop_left_d;
	logic                          ascent_d;
	logic                          nostop_d;
	logic                          apply;

	// Sample register
	logic                               valid_s1;
	logic        [dsm_pkg::DEPTH_W-1:0] depth_s1;
	logic signed [dsm_pkg::NSM_W-1:0]   nsm_s1;

	// Result register
	logic                          res_valid_q;

	logic                  advance;
	logic                  step;
	logic                  cfg_wr;
	dsm_pkg::reg_idx_t     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = dsm_pkg::reg_idx_t'(paddr[dsm_pkg::APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q           <= dsm_pkg::RST_TICKS_PER_SECOND;
			stop_len_q      <= dsm_pkg::RST_SAFETY_STOP_SECONDS;
			req_depth_q     <= dsm_pkg::RST_REQUIRE_STOP_DEPTH;
			deep_lim_q      <= dsm_pkg::RST_STOP_DEEP_LIMIT;
			shallow_lim_q   <= dsm_pkg::RST_STOP_SHALLOW_LIMIT;
			start_depth_q   <= dsm_pkg::RST_DIVE_START_DEPTH;
			ascent_lim_q    <= dsm_pkg::RST_ASCENT_LIMIT;
			start_in_dive_q <= dsm_pkg::RST_START_IN_DIVE;
		end else if (cfg_wr) begin
			case (reg_idx)
				dsm_pkg::REG_TICKS_PER_SECOND:    tps_q <= pwdata[dsm_pkg::TICK_W-1:0];
				dsm_pkg::REG_SAFETY_STOP_SECONDS:
					stop_len_q <= pwdata[dsm_pkg::STOPSEC_W-1:0];
				dsm_pkg::REG_REQUIRE_STOP_DEPTH:  req_depth_q <= pwdata[dsm_pkg::DEPTH_W-1:0];
				dsm_pkg::REG_STOP_DEEP_LIMIT:     deep_lim_q <= pwdata[dsm_pkg::DEPTH_W-1:0];
				dsm_pkg::REG_STOP_SHALLOW_LIMIT:
					shallow_lim_q <= pwdata[dsm_pkg::DEPTH_W-1:0];
				dsm_pkg::REG_DIVE_START_DEPTH:
					start_depth_q <= pwdata[dsm_pkg::DEPTH_W-1:0];
				dsm_pkg::REG_ASCENT_LIMIT:        ascent_lim_q <= pwdata[dsm_pkg::DEPTH_W-1:0];
				dsm_pkg::REG_START_IN_DIVE:       start_in_dive_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		prdata = '0;
		case (reg_idx)
			dsm_pkg::REG_TICKS_PER_SECOND:    prdata[dsm_pkg::TICK_W-1:0] = tps_q;
			dsm_pkg::REG_SAFETY_STOP_SECONDS: prdata[dsm_pkg::STOPSEC_W-1:0] = stop_len_q;
			dsm_pkg::REG_REQUIRE_STOP_DEPTH:  prdata[dsm_pkg::DEPTH_W-1:0] = req_depth_q;
			dsm_pkg::REG_STOP_DEEP_LIMIT:     prdata[dsm_pkg::DEPTH_W-1:0] = deep_lim_q;
			dsm_pkg::REG_STOP_SHALLOW_LIMIT:  prdata[dsm_pkg::DEPTH_W-1:0] = shallow_lim_q;
			dsm_pkg::REG_DIVE_START_DEPTH:    prdata[dsm_pkg::DEPTH_W-1:0] = start_depth_q;
			dsm_pkg::REG_ASCENT_LIMIT:        prdata[dsm_pkg::DEPTH_W-1:0] = ascent_lim_q;
			dsm_pkg::REG_START_IN_DIVE:       prdata[0] = start_in_dive_q;
			default: ;
		endcase
	end

	// Handshake: the result register frees when empty or taken
	assign advance       = !res_valid_q || results.ready;
	assign step          = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	// Sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			depth_s1 <= samples.depth_sample;
			nsm_s1   <= samples.no_stop_minutes;
		end
	end

	// Update logic for one tick
	always_comb begin
		dive_d      = dive_q;
		deepest_d   = deepest_q;
		tick_d      = tick_q;
		sec_d       = sec_q;
		min_d       = min_q;
		hour_d      = hour_q;
		owe_d       = owe_q;
		in_stop_d   = in_stop_q;
		stop_left_d = stop_left_q;
		ascent_d    = ascent_q;
		nostop_d    = nostop_q;
		apply       = 1'b1;

		// dive clock and stop countdown, from the previous depth
		if (dive_q) begin
			tick_d = tick_q + 1'b1;
			if (tick_d >= tps_q) begin
				tick_d = '0;
				if (sec_q >= dsm_pkg::SEC_PER_MIN) begin
					sec_d = '0;
					if (min_q >= dsm_pkg::MIN_PER_HR) begin
						min_d = '0;
						if (hour_q != dsm_pkg::HOUR_MAX)
							hour_d = hour_q + 1'b1;
					end else begin
						min_d = min_q + 1'b1;
					end
				end else begin
					sec_d = sec_q + 1'b1;
				end
				if (in_stop_q) begin
					if (last_depth_q <= deep_lim_q && last_depth_q >= shallow_lim_q &&
					    stop_left_q != '0)
						stop_left_d = stop_left_q - 1'b1;
					if (stop_left_d == '0)
						in_stop_d = 1'b0;
				end
			end
		end

		// surface mode: start a dive or only note the depth
		if (!dive_q) begin
			if (depth_s1 < start_depth_q) begin
				apply = 1'b0;
			end else begin
				dive_d    = 1'b1;
				sec_d     = '0;
				min_d     = '0;
				hour_d    = '0;
				deepest_d = depth_s1;
			end
		end

		// new sample: max depth, stop owed and started, alarms
		if (apply) begin
			if (depth_s1 > deepest_d)
				deepest_d = depth_s1;
			if (!owe_d && depth_s1 > req_depth_q)
				owe_d = 1'b1;
			if (owe_d && depth_s1 <= deep_lim_q) begin
				owe_d       = 1'b0;
				in_stop_d   = 1'b1;
				stop_left_d = stop_len_q;
			end
			ascent_d = (last_depth_q > depth_s1) &&
			           ((last_depth_q - depth_s1) > ascent_lim_q);
			nostop_d = (nsm_s1 == '0) || nsm_s1[dsm_pkg::NSM_W-1];
		end
	end

	// State commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dive_q       <= dsm_pkg::RST_START_IN_DIVE;
			last_depth_q <= '0;
			deepest_q    <= '0;
			tick_q       <= '0;
			sec_q        <= '0;
			min_q        <= '0;
			hour_q       <= '0;
			owe_q        <= 1'b0;
			in_stop_q    <= 1'b0;
			stop_left_q  <= '0;
			ascent_q     <= 1'b0;
			nostop_q     <= 1'b0;
		end else if (step) begin
			dive_q       <= dive_d;
			last_depth_q <= depth_s1;
			deepest_q    <= deepest_d;
			tick_q       <= tick_d;
			sec_q        <= sec_d;
			min_q        <= min_d;
			hour_q       <= hour_d;
			owe_q        <= owe_d;
			in_stop_q    <= in_stop_d;
			stop_left_q  <= stop_left_d;
			ascent_q     <= ascent_d;
			nostop_q     <= nostop_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			results.diving            <= dive_d;
			results.max_depth         <= deepest_d;
			results.dive_hours        <= hour_d;
			results.dive_minutes      <= min_d;
			results.dive_seconds      <= sec_d;
			results.stop_required     <= owe_d;
			results.stop_active       <= in_stop_d;
			results.stop_seconds_left <= stop_left_d;
			results.ascent_alarm      <= ascent_d;
			results.no_stop_alarm     <= nostop_d;
			results.buzzer_on         <= ascent_d | nostop_d;
			results.led_on            <= nostop_d;
		end
	end

	assign results.valid = res_valid_q;

endmodule : dive_safety_stop_monitor

`default_nettype wire
